// ===== rtl/ecc_pkg.sv =====
// Shared types, constants and calendar helper functions for the epoch seconds converter.
package ecc_pkg;

    localparam logic        CMD_TO_CAL   = 1'b0;
    localparam logic        CMD_TO_SECS  = 1'b1;
    localparam logic        REG_EPOCH    = 1'b0;

    localparam logic [13:0] EPOCH_RESET  = 14'd1970;
    localparam logic [14:0] YEAR_LIMIT   = 15'd9999;
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;
    localparam logic [16:0] SECS_PER_HR  = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN = 17'd60;
    localparam logic [16:0] LEAP_CYCLE   = 17'd400;
    localparam logic [8:0]  LEAP_LAST    = 9'd399;
    localparam logic [8:0]  DAYS_YEAR    = 9'd365;
    localparam logic [8:0]  DAYS_LEAP    = 9'd366;
    localparam logic [3:0]  MONTH_LAST   = 4'd12;

    // floor(2^32 / d): for any 32-bit n, (n * r) >> 32 is n / d or one short of it
    localparam logic [63:0] TWO_POW_32   = 64'h1_0000_0000;
    localparam logic [31:0] RECIP_DAY    = 32'(TWO_POW_32 / 64'(SECS_PER_DAY));
    localparam logic [31:0] RECIP_HR     = 32'(TWO_POW_32 / 64'(SECS_PER_HR));
    localparam logic [31:0] RECIP_MIN    = 32'(TWO_POW_32 / 64'(SECS_PER_MIN));
    localparam logic [31:0] RECIP_CYCLE  = 32'(TWO_POW_32 / 64'(LEAP_CYCLE));

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDIV,
        S_C0_DAY,
        S_C0_YEAR,
        S_C0_MON,
        S_C0_HR,
        S_C0_MIN,
        S_C1_YDIV,
        S_C1_SUM,
        S_C1_SCALE,
        S_C1_TOD
    } t_state;

    typedef struct packed {
        logic        cmd;
        logic [31:0] seconds_in;
        logic [13:0] year_in;
        logic [3:0]  month_in;
        logic [4:0]  day_in;
        logic [4:0]  hour_in;
        logic [5:0]  minute_in;
        logic [5:0]  second_in;
    } t_item;

    typedef struct packed {
        logic        status;
        logic [31:0] seconds_out;
        logic [13:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [4:0]  hour_out;
        logic [5:0]  minute_out;
        logic [5:0]  second_out;
    } t_result;

    typedef struct packed {
        logic        start;
        logic [31:0] recip;
        logic [16:0] den;
        logic [31:0] num;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
        logic [16:0] rem;
    } t_div_rsp;

    // leap test from the year modulo 400
    function automatic logic is_leap_m400(input logic [8:0] m);
        return (m[1:0] == 2'b00) && !(m inside {9'd100, 9'd200, 9'd300});
    endfunction

    // whole centuries in a remainder below 400
    function automatic logic [1:0] cent_of(input logic [8:0] r);
        logic [1:0] c;
        if (r >= 9'd300)      c = 2'd3;
        else if (r >= 9'd200) c = 2'd2;
        else if (r >= 9'd100) c = 2'd1;
        else                  c = 2'd0;
        return c;
    endfunction

    // y/4 - y/100 + y/400 taken at y-1, given y = 400*q + r and y >= 1
    function automatic logic [15:0] leap_count(input logic [13:0] y, input logic [5:0] q,
                                               input logic [8:0] r);
        logic [13:0] x;
        logic [5:0]  qx;
        logic [8:0]  rx;
        logic [15:0] q3;
        x = y - 14'd1;
        if (r == 9'd0) begin
            qx = q - 6'd1;
            rx = LEAP_LAST;
        end else begin
            qx = q;
            rx = r - 9'd1;
        end
        q3 = {10'd0, qx} * 16'd3;
        return {4'd0, x[13:2]} - q3 - {14'd0, cent_of(rx)};
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon)
            4'd2:                       len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
            default:                    len = 5'd31;
        endcase
        return len;
    endfunction

    // days beyond 28 per month, accumulated ahead of month index (0 = January)
    function automatic logic [4:0] month_extra(input logic [3:0] idx);
        logic [4:0] e;
        case (idx)
            4'd0:    e = 5'd0;
            4'd1:    e = 5'd3;
            4'd2:    e = 5'd3;
            4'd3:    e = 5'd6;
            4'd4:    e = 5'd8;
            4'd5:    e = 5'd11;
            4'd6:    e = 5'd13;
            4'd7:    e = 5'd16;
            4'd8:    e = 5'd19;
            4'd9:    e = 5'd21;
            4'd10:   e = 5'd24;
            4'd11:   e = 5'd26;
            default: e = 5'd0;
        endcase
        return e;
    endfunction

endpackage

// ===== rtl/ecc_div.sv =====
// Shared constant divider: reciprocal multiply, back-multiply, one correction step.
module ecc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ecc_pkg::t_div_req i_req,
    output ecc_pkg::t_div_rsp o_rsp
);
    import ecc_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [1:0]  r_cnt;
    logic [31:0] r_num;
    logic [31:0] r_recip;
    logic [16:0] r_den;
    logic [31:0] r_est;
    logic [17:0] r_part;
    logic [16:0] r_rem;
    logic [31:0] r_quo;
    logic [63:0] prod;
    logic [17:0] back;
    logic [17:0] part;
    logic [17:0] fix;
    logic        load;

    // hold off a reload while the previous answer is still on show
    assign load = i_req.start && !r_busy && !r_done;
    assign prod = {32'd0, r_num} * {32'd0, r_recip};
    // the estimate is at most one short, so the remainder stays below twice the divisor
    assign back = r_est[17:0] * {1'b0, r_den};
    assign part = r_num[17:0] - back;
    assign fix  = r_part - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == 2'd2);
            if (load) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == 2'd2)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cnt   <= 2'd0;
            r_num   <= i_req.num;
            r_recip <= i_req.recip;
            r_den   <= i_req.den;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 2'd1;
            case (r_cnt)
                2'd0: begin
                    r_est <= 32'(prod >> 32);
                end
                2'd1: begin
                    r_quo  <= r_est;
                    r_part <= part;
                end
                default: begin
                    if (r_part >= {1'b0, r_den}) begin
                        r_quo <= r_quo + 32'd1;
                        r_rem <= fix[16:0];
                    end else begin
                        r_rem <= r_part[16:0];
                    end
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

// ===== rtl/epoch_seconds_calendar_converter.sv =====
// Top level: config register, conversion sequencer and result register of the converter.
// Both start with the epoch divide. Seconds to calendar: day divide, walk over whole years
// (up to 136) and months (1 to 12), hour and minute divides; zero seconds ends after the
// epoch divide, a year past 9999 after the year walk. Calendar to seconds: divide, sum, scale.
// One transaction at a time; busy falls with the result strobe; the result then stays held.
// Synchronous active-low reset: sequencer idle, no strobe, epoch year back to 1970.
module epoch_seconds_calendar_converter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  ecc_pkg::t_item   i_item,
    output logic             o_strobe,
    output ecc_pkg::t_result o_result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ecc_pkg::*;

    t_state      r_state, n_state;
    t_item       r_in, n_in;
    t_result     r_res, n_res;
    logic        r_strobe, n_strobe;
    logic [13:0] r_epoch;
    logic [3:0]  r_mon, n_mon;
    logic [5:0]  r_qe, n_qe;
    logic [8:0]  r_m400, n_m400;
    logic [5:0]  r_qy, n_qy;
    logic [8:0]  r_ry, n_ry;
    logic [14:0] r_year, n_year;
    logic [15:0] r_days, n_days;
    logic [16:0] r_left, n_left;
    logic [3:0]  r_month, n_month;
    logic [4:0]  r_dom, n_dom;
    logic [4:0]  r_hour, n_hour;
    logic [31:0] r_acc, n_acc;

    t_div_req    div_req;
    t_div_rsp    div_rsp;

    logic        c0_leap;
    logic [8:0]  c0_ydays;
    logic [4:0]  c0_mlen;
    logic        c1_gt;
    logic [13:0] c1_yd;
    logic [15:0] c1_fe;
    logic [15:0] c1_leaps;
    logic [3:0]  c1_monm1;
    logic [8:0]  c1_moff;
    logic [31:0] c1_doy;
    logic [16:0] c1_hsec;
    logic [11:0] c1_msec;

    ecc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_EPOCH) ? {18'd0, r_epoch} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch <= EPOCH_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_EPOCH)) begin
            r_epoch <= pwdata[13:0];
        end
    end

    // seconds to calendar helpers
    assign c0_leap  = is_leap_m400(r_m400);
    assign c0_ydays = c0_leap ? DAYS_LEAP : DAYS_YEAR;
    assign c0_mlen  = month_len(r_month, c0_leap);

    // calendar to seconds helpers
    assign c1_gt    = r_in.year_in > r_epoch;
    assign c1_yd    = c1_gt ? (r_in.year_in - r_epoch) : 14'd0;
    assign c1_fe    = (r_epoch == 14'd0) ? 16'hFFFF : leap_count(r_epoch, r_qe, r_m400);
    assign c1_leaps = c1_gt ? (leap_count(r_in.year_in, r_qy, r_ry) - c1_fe) : 16'd0;
    assign c1_monm1 = r_mon - 4'd1;
    assign c1_moff  = {5'd0, c1_monm1} * 9'd28;
    assign c1_doy   = {27'd0, r_in.day_in} - 32'd1 + {23'd0, c1_moff}
                    + {27'd0, month_extra(c1_monm1)}
                    + {31'd0, (r_mon > 4'd2) && is_leap_m400(r_ry)};
    assign c1_hsec  = {12'd0, r_in.hour_in} * SECS_PER_HR;
    assign c1_msec  = {6'd0, r_in.minute_in} * SECS_PER_MIN[11:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in    <= n_in;
        r_res   <= n_res;
        r_mon   <= n_mon;
        r_qe    <= n_qe;
        r_m400  <= n_m400;
        r_qy    <= n_qy;
        r_ry    <= n_ry;
        r_year  <= n_year;
        r_days  <= n_days;
        r_left  <= n_left;
        r_month <= n_month;
        r_dom   <= n_dom;
        r_hour  <= n_hour;
        r_acc   <= n_acc;
    end

    always_comb begin
        n_state  = r_state;
        n_in     = r_in;
        n_res    = r_res;
        n_strobe = 1'b0;
        n_mon    = r_mon;
        n_qe     = r_qe;
        n_m400   = r_m400;
        n_qy     = r_qy;
        n_ry     = r_ry;
        n_year   = r_year;
        n_days   = r_days;
        n_left   = r_left;
        n_month  = r_month;
        n_dom    = r_dom;
        n_hour   = r_hour;
        n_acc    = r_acc;
        div_req  = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_in = i_item;
                    if (i_item.month_in == 4'd0) begin
                        n_mon = 4'd1;
                    end else if (i_item.month_in > MONTH_LAST) begin
                        n_mon = MONTH_LAST;
                    end else begin
                        n_mon = i_item.month_in;
                    end
                    n_state = S_EDIV;
                end
            end
            S_EDIV: begin
                div_req.start = 1'b1;
                div_req.num   = {18'd0, r_epoch};
                div_req.den   = LEAP_CYCLE;
                div_req.recip = RECIP_CYCLE;
                if (div_rsp.done) begin
                    n_qe   = div_rsp.quo[5:0];
                    n_m400 = div_rsp.rem[8:0];
                    n_year = {1'b0, r_epoch};
                    if (r_in.cmd == CMD_TO_SECS) begin
                        n_state = S_C1_YDIV;
                    end else if (r_in.seconds_in == 32'd0) begin
                        n_res        = '0;
                        n_res.status = 1'b1;
                        n_strobe     = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_state = S_C0_DAY;
                    end
                end
            end
            S_C0_DAY: begin
                div_req.start = 1'b1;
                div_req.num   = r_in.seconds_in;
                div_req.den   = SECS_PER_DAY;
                div_req.recip = RECIP_DAY;
                if (div_rsp.done) begin
                    n_days  = div_rsp.quo[15:0];
                    n_left  = div_rsp.rem;
                    n_state = S_C0_YEAR;
                end
            end
            S_C0_YEAR: begin
                if (r_days >= {7'd0, c0_ydays}) begin
                    n_days = r_days - {7'd0, c0_ydays};
                    n_year = r_year + 15'd1;
                    n_m400 = (r_m400 == LEAP_LAST) ? 9'd0 : (r_m400 + 9'd1);
                end else if (r_year > YEAR_LIMIT) begin
                    n_res        = '0;
                    n_res.status = 1'b1;
                    n_strobe     = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_month = 4'd1;
                    n_state = S_C0_MON;
                end
            end
            S_C0_MON: begin
                if ((r_days < {11'd0, c0_mlen}) || (r_month == MONTH_LAST)) begin
                    n_dom   = r_days[4:0] + 5'd1;
                    n_state = S_C0_HR;
                end else begin
                    n_days  = r_days - {11'd0, c0_mlen};
                    n_month = r_month + 4'd1;
                end
            end
            S_C0_HR: begin
                div_req.start = 1'b1;
                div_req.num   = {15'd0, r_left};
                div_req.den   = SECS_PER_HR;
                div_req.recip = RECIP_HR;
                if (div_rsp.done) begin
                    n_hour  = div_rsp.quo[4:0];
                    n_left  = div_rsp.rem;
                    n_state = S_C0_MIN;
                end
            end
            S_C0_MIN: begin
                div_req.start = 1'b1;
                div_req.num   = {15'd0, r_left};
                div_req.den   = SECS_PER_MIN;
                div_req.recip = RECIP_MIN;
                if (div_rsp.done) begin
                    n_res            = '0;
                    n_res.year_out   = r_year[13:0];
                    n_res.month_out  = r_month;
                    n_res.day_out    = r_dom;
                    n_res.hour_out   = r_hour;
                    n_res.minute_out = div_rsp.quo[5:0];
                    n_res.second_out = div_rsp.rem[5:0];
                    n_strobe         = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_C1_YDIV: begin
                div_req.start = 1'b1;
                div_req.num   = {18'd0, r_in.year_in};
                div_req.den   = LEAP_CYCLE;
                div_req.recip = RECIP_CYCLE;
                if (div_rsp.done) begin
                    n_qy    = div_rsp.quo[5:0];
                    n_ry    = div_rsp.rem[8:0];
                    n_state = S_C1_SUM;
                end
            end
            S_C1_SUM: begin
                // whole years since the epoch, then the day of the year
                n_acc   = ({18'd0, c1_yd} * {23'd0, DAYS_YEAR}) + {16'd0, c1_leaps} + c1_doy;
                n_state = S_C1_SCALE;
            end
            S_C1_SCALE: begin
                n_acc   = r_acc * {15'd0, SECS_PER_DAY};
                n_state = S_C1_TOD;
            end
            S_C1_TOD: begin
                n_res             = '0;
                n_res.seconds_out = r_acc + {15'd0, c1_hsec} + {20'd0, c1_msec}
                                  + {26'd0, r_in.second_in};
                n_strobe          = 1'b1;
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

`ifndef ASSERT_OFF
    a_strobe_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a transaction in progress");

    a_div_done_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_EDIV || r_state == S_C0_DAY || r_state == S_C0_HR ||
                          r_state == S_C0_MIN || r_state == S_C1_YDIV))
        else $error("divider finished outside a divide step");

    a_cal_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && r_in.cmd == CMD_TO_CAL && !o_result.status) |->
        (o_result.month_out >= 4'd1 && o_result.month_out <= MONTH_LAST &&
         o_result.day_out != 5'd0 && o_result.hour_out < 5'd24))
        else $error("calendar result field out of range");

    a_secs_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && r_in.cmd == CMD_TO_SECS) |->
        (!o_result.status && o_result.year_out == 14'd0 && o_result.month_out == 4'd0))
        else $error("seconds result carries calendar fields");
`endif

endmodule

// ===== sim/epoch_calendar_checker.sv =====
`timescale 1ns / 1ps
// Checker for the epoch seconds converter: predicts each transaction's result and compares it.
module epoch_calendar_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  ecc_pkg::t_item   i_item,
    input  logic             i_strobe,
    input  ecc_pkg::t_result i_result,
    input  logic             i_psel,
    input  logic             i_penable,
    input  logic             i_pwrite,
    input  logic             i_pready,
    input  logic [2:0]       i_paddr,
    input  logic [31:0]      i_pwdata,
    output int               o_fail_count,
    output int               o_pending
);
    import ecc_pkg::*;

    localparam logic [2:0] EPOCH_ADDR = {REG_EPOCH, 2'b00};

    int unsigned days_in_month [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    // days beyond 28 per month, summed over the months ahead
    int unsigned days_past_28 [12] = '{0, 3, 3, 6, 8, 11, 13, 16, 19, 21, 24, 26};

    t_result     expected_results [$];
    logic [13:0] epoch_now = EPOCH_RESET;
    int          mismatches = 0;
    int          results_seen = 0;

    function automatic bit leap_year(input int unsigned y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic int unsigned year_length(input int unsigned y);
        return leap_year(y) ? 366 : 365;
    endfunction

    function automatic t_result convert_epoch_time(input t_item it, input int unsigned epoch);
        t_result     r;
        int unsigned days, rest, yr, mon, len, y;
        r = '0;
        if (it.cmd == CMD_TO_CAL) begin
            if (it.seconds_in == 32'd0) begin
                r.status = 1'b1;
            end else begin
                days = it.seconds_in / SECS_PER_DAY;
                rest = it.seconds_in % SECS_PER_DAY;
                yr   = epoch;
                while (days >= year_length(yr)) begin
                    days -= year_length(yr);
                    yr++;
                end
                if (yr > YEAR_LIMIT) begin
                    r.status = 1'b1;
                end else begin
                    mon = 1;
                    len = days_in_month[1];
                    while (days >= len && mon != MONTH_LAST) begin
                        days -= len;
                        mon++;
                        len = (mon == 2 && leap_year(yr)) ? 29 : days_in_month[mon];
                    end
                    r.year_out   = yr[13:0];
                    r.month_out  = mon[3:0];
                    r.day_out    = 5'(days + 1);
                    r.hour_out   = 5'(rest / SECS_PER_HR);
                    r.minute_out = 6'((rest % SECS_PER_HR) / SECS_PER_MIN);
                    r.second_out = 6'(rest % SECS_PER_MIN);
                end
            end
        end else begin
            // out-of-range months are clamped, day and time of day taken as given
            if (it.month_in == 4'd0)
                mon = 1;
            else if (it.month_in > MONTH_LAST)
                mon = MONTH_LAST;
            else
                mon = it.month_in;
            days = 32'(it.day_in) - 32'd1 + (mon - 1) * 28 + days_past_28[mon - 1];
            if (mon > 2 && leap_year(it.year_in))
                days++;
            for (y = epoch; y < it.year_in; y++)
                days += year_length(y);
            r.seconds_out = days * SECS_PER_DAY + it.hour_in * SECS_PER_HR
                          + it.minute_in * SECS_PER_MIN + it.second_in;
        end
        return r;
    endfunction

    function automatic string show(input t_result r);
        return $sformatf("st=%0d secs=%0d %0d-%0d-%0d %0d:%0d:%0d", r.status, r.seconds_out,
                         r.year_out, r.month_out, r.day_out, r.hour_out, r.minute_out,
                         r.second_out);
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            epoch_now = EPOCH_RESET;
        end else begin
            if (i_strobe) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d with no transaction outstanding: %s",
                                 results_seen, show(i_result));
                end else begin
                    want = expected_results.pop_front();
                    if (i_result.status !== want.status
                            || i_result.seconds_out !== want.seconds_out
                            || i_result.year_out !== want.year_out
                            || i_result.month_out !== want.month_out
                            || i_result.day_out !== want.day_out
                            || i_result.hour_out !== want.hour_out
                            || i_result.minute_out !== want.minute_out
                            || i_result.second_out !== want.second_out) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d mismatch: expected %s, got %s",
                                     results_seen, show(want), show(i_result));
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == EPOCH_ADDR)
                epoch_now = i_pwdata[13:0];
            if (i_start && !i_busy)
                expected_results.push_back(convert_epoch_time(i_item, epoch_now));
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_results.size();
    end

endmodule

// ===== sim/epoch_seconds_calendar_converter_test.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, stimulus and verdict for the epoch seconds converter.
module epoch_seconds_calendar_converter_test;
    import ecc_pkg::*;

    localparam logic [2:0] EPOCH_ADDR = {REG_EPOCH, 2'b00};
    localparam int unsigned DAY_SECS  = 86400;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_item       i_item;
    logic        o_strobe;
    t_result     o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;

    always #2 i_clk = ~i_clk;

    epoch_seconds_calendar_converter i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    epoch_calendar_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic t_item seconds_item(input logic [31:0] secs);
        t_item it;
        it            = '0;
        it.cmd        = CMD_TO_CAL;
        it.seconds_in = secs;
        return it;
    endfunction

    function automatic t_item date_item(input int unsigned y, input int unsigned mo,
                                        input int unsigned d, input int unsigned h,
                                        input int unsigned mi, input int unsigned s);
        t_item it;
        it           = '0;
        it.cmd       = CMD_TO_SECS;
        it.year_in   = y[13:0];
        it.month_in  = mo[3:0];
        it.day_in    = d[4:0];
        it.hour_in   = h[4:0];
        it.minute_in = mi[5:0];
        it.second_in = s[5:0];
        return it;
    endfunction

    // random transaction; dates mostly fall within the span a 32-bit count reaches
    function automatic t_item random_item(input int unsigned epoch);
        logic [95:0] raw;
        t_item       it;
        int unsigned pick, yr;
        raw  = {$urandom, $urandom, $urandom};
        it   = raw[$bits(t_item)-1:0];
        pick = $urandom_range(0, 99);
        if (it.cmd == CMD_TO_CAL) begin
            if (pick < 3)
                it.seconds_in = '0;
            else if (pick < 35)
                it.seconds_in = $urandom_range(0, DAY_SECS * 400);
            else if (pick < 45)
                it.seconds_in = $urandom_range(1, DAY_SECS * 3);
        end else begin
            if (pick < 70)
                yr = epoch + $urandom_range(0, 140) - 5;
            else
                yr = $urandom_range(1000, 9999);
            if (yr < 1000)
                yr = 1000;
            if (yr > 9999)
                yr = 9999;
            it.year_in = yr[13:0];
            if ($urandom_range(0, 9) != 0)
                it.month_in = 4'($urandom_range(1, 12));
            if ($urandom_range(0, 9) != 0)
                it.day_in = 5'($urandom_range(1, 31));
            if ($urandom_range(0, 9) != 0)
                it.hour_in = 5'($urandom_range(0, 23));
            if ($urandom_range(0, 9) != 0)
                it.minute_in = 6'($urandom_range(0, 59));
            if ($urandom_range(0, 9) != 0)
                it.second_in = 6'($urandom_range(0, 59));
        end
        return it;
    endfunction

    // called just after a rising edge; returns just after the accepting edge or the gap
    task automatic send_item(input t_item it, input int unsigned idle_pct);
        int unsigned gap;
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 13) : 0;
        if (gap != 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic hold_off();
        @(negedge i_clk);
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0 || busy !== 1'b0);
    endtask

    task automatic write_epoch(input int unsigned value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= EPOCH_ADDR;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned epochs [8];
        int unsigned epoch, idle_pct, count;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, epoch year still at its reset value
        send_item(seconds_item(32'd0), 0);
        send_item(seconds_item(32'd1), 0);
        send_item(seconds_item(32'd86399), 20);
        send_item(seconds_item(32'd86400), 0);
        send_item(seconds_item(32'd951782400), 0);      // leap day of 2000
        send_item(seconds_item(32'd951868800), 50);
        send_item(seconds_item(32'd4107542400), 0);
        send_item(seconds_item(32'hFFFF_FFFF), 0);
        send_item(date_item(1970, 1, 1, 0, 0, 0), 0);
        send_item(date_item(9999, 12, 31, 23, 59, 59), 0);
        send_item(date_item(1000, 6, 15, 12, 30, 30), 50);  // before the epoch
        send_item(date_item(2000, 3, 1, 0, 0, 1), 0);
        send_item(date_item(1900, 3, 1, 1, 2, 3), 0);
        send_item(date_item(2100, 3, 1, 4, 5, 6), 0);
        send_item(date_item(2024, 0, 10, 8, 9, 10), 0);
        send_item(date_item(2024, 13, 10, 8, 9, 10), 0);
        send_item(date_item(2024, 15, 10, 8, 9, 10), 30);
        send_item(date_item(2024, 2, 0, 0, 0, 0), 0);
        send_item(date_item(2024, 7, 31, 31, 63, 63), 0);

        epochs[0] = 1000;
        epochs[1] = 9999;
        epochs[2] = 16383;      // beyond the last valid year
        epochs[3] = 2000;
        epochs[4] = $urandom_range(1000, 9999);
        epochs[5] = $urandom_range(1000, 9999);
        epochs[6] = $urandom_range(1000, 9999);
        epochs[7] = 1970;
        idle_pct  = 0;

        foreach (epochs[p]) begin
            hold_off();
            write_epoch(epochs[p]);
            epoch = epochs[p];
            send_item(seconds_item(32'd1), idle_pct);
            send_item(seconds_item(32'hFFFF_FFFF), idle_pct);
            send_item(seconds_item(DAY_SECS * 365), idle_pct);
            send_item(seconds_item(DAY_SECS * 366 - 1), idle_pct);
            send_item(date_item(epoch, 1, 1, 0, 0, 0), idle_pct);
            send_item(date_item(9999, 12, 31, 23, 59, 59), idle_pct);
            count = (epoch > 9999) ? 20 : 190;
            for (int i = 0; i < count; i++) begin
                if (i % 20 == 0) begin
                    case ($urandom_range(0, 2))
                        0:       idle_pct = 0;
                        1:       idle_pct = 25;
                        default: idle_pct = 60;
                    endcase
                    if (p == 7)
                        idle_pct = 0;
                end
                send_item(random_item(epoch), idle_pct);
            end
        end

        hold_off();
        repeat (250) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
